// ----- sv/pcpf_pkg.sv -----
// Package for the folded path common-prefix block.
// Holds the item payload types, command codes and the case-fold function.
// No dependencies.
package pcpf_pkg;

    typedef enum logic [1:0] {
        CMD_PAIR    = 2'd0,
        CMD_READ    = 2'd1,
        CMD_MISSING = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    localparam logic [7:0]  BACKSLASH = 8'h5C;
    localparam logic [15:0] SEP_NONE  = 16'hFFFF;

    typedef struct packed {
        logic [1:0] command;
        logic       first_pair;
        logic [7:0] a_byte;
        logic [7:0] b_byte;
        logic [8:0] read_index;
    } pair_t;

    typedef struct packed {
        logic        finished;
        logic [15:0] prefix_count;
        logic [8:0]  copied_length;
        logic        buffer_written;
        logic [7:0]  out_byte;
    } result_t;

    // Map a byte to its case-folded form
    function automatic logic [7:0] fold(input logic [7:0] v);
        logic [7:0] r;
        begin
            r = v;
            if ((v >= 8'h61 && v <= 8'h7A) || (v >= 8'hE0 && v <= 8'hF6) ||
                (v >= 8'hF8 && v <= 8'hFE))
            begin
                r = v - 8'h20;
            end
            else
            begin
                case (v)
                    8'h88:   r = 8'h5E;
                    8'h9A:   r = 8'h8A;
                    8'h9C:   r = 8'h8C;
                    8'h9E:   r = 8'h8E;
                    8'hFF:   r = 8'h9F;
                    default: r = v;
                endcase
            end
            return r;
        end
    endfunction

endpackage

// ----- sv/pcpf_if.sv -----
// Valid/ready channel interfaces for the folded path common-prefix block.
// Depends on pcpf_pkg for the payload types.
interface pcpf_pair_if;
    logic             valid;
    logic             ready;
    pcpf_pkg::pair_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pcpf_result_if;
    logic               valid;
    logic               ready;
    pcpf_pkg::result_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/path_common_prefix_folded.sv -----
// Top level of the folded path common-prefix block.
// Depends on pcpf_pkg and the channel interfaces in pcpf_if.sv.
//
// Accepts one item per clock cycle unless the result side stalls it; each item
// gives one result, registered first in stage 1 (compare state updated, path A
// byte store read issued) and then in the output register, with the store's
// registered read data. Path A's bytes live in a single-port-write,
// single-port-read memory of PATH_LIMIT bytes; a read of the entry written by
// the same item is forwarded around the memory. The copy_enabled register is
// sampled when a comparison settles. No clearing pass after reset.
module path_common_prefix_folded #(
    parameter int PATH_LIMIT = 260
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    pcpf_pair_if.sink            pair,
    pcpf_result_if.source        result
);

    localparam int AW = $clog2(PATH_LIMIT);

    // Compare state
    logic [15:0]   pos_reg,   pos_next;
    logic [15:0]   sep_reg,   sep_next;
    logic          sws_reg,   sws_next;
    logic          stop_reg,  stop_next;
    logic [15:0]   cnt_reg,   cnt_next;
    logic [AW-1:0] len_reg,   len_next;
    logic          wr_reg,    wr_next;
    logic          copy_en_reg;

    // Stage 1 (memory read in flight) and output register
    logic          s1_valid_reg;
    logic          s1_fin_reg;
    logic [15:0]   s1_cnt_reg;
    logic [8:0]    s1_len_reg;
    logic          s1_wr_reg;
    logic          s1_rd_ok_reg;
    logic          s1_fwd_reg;
    logic [7:0]    s1_fwd_byte_reg;
    logic          out_valid_reg;
    pcpf_pkg::result_t out_data_reg;

    // Memory
    logic [7:0]    mem [PATH_LIMIT];
    logic [7:0]    mem_q_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic          rd_ok;
    logic          fwd;

    // Helpers
    logic          accept;
    logic          s1_adv;
    logic          out_free;
    logic [15:0]   pos_e;
    logic [15:0]   n;
    logic [16:0]   la_known;
    logic [16:0]   wn;
    logic          mismatch;
    logic          both_end;
    logic          sep_end;
    logic [15:0]   len16;
    logic [15:0]   ridx16;
    logic [7:0]    a;
    logic [7:0]    b;

    assign a        = pair.data.a_byte;
    assign b        = pair.data.b_byte;
    assign out_free = !out_valid_reg || result.ready;
    assign s1_adv   = !s1_valid_reg || out_free;
    assign accept   = pair.valid && s1_adv;

    assign pair.ready   = s1_adv;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // Compute the next compare state for an accepted item
    always_comb
    begin
        pos_next  = pos_reg;
        sep_next  = sep_reg;
        sws_next  = sws_reg;
        stop_next = stop_reg;
        cnt_next  = cnt_reg;
        len_next  = len_reg;
        wr_next   = wr_reg;
        mem_we    = 1'b0;
        pos_e     = pair.data.first_pair ? 16'd0 : pos_reg;
        mem_waddr = pos_e[AW-1:0];
        mismatch  = (a == 8'd0) || (b == 8'd0) ||
                    (pcpf_pkg::fold(a) != pcpf_pkg::fold(b));
        both_end  = (a == 8'd0) && (b == 8'd0);
        sep_end   = ((a == 8'd0) && (b == pcpf_pkg::BACKSLASH)) ||
                    ((b == 8'd0) && (a == pcpf_pkg::BACKSLASH));
        n         = 16'd0;
        la_known  = 17'd0;
        wn        = 17'd0;
        if (accept)
        begin
            case (pair.data.command)
                pcpf_pkg::CMD_PAIR:
                begin
                    if (pair.data.first_pair)
                    begin
                        pos_next  = 16'd0;
                        sep_next  = pcpf_pkg::SEP_NONE;
                        sws_next  = 1'b0;
                        stop_next = 1'b0;
                        cnt_next  = 16'd0;
                        len_next  = '0;
                        wr_next   = 1'b0;
                    end
                    if (!stop_next)
                    begin
                        mem_we = (pos_e < 16'(PATH_LIMIT));
                        if (pos_e == 16'd0)
                        begin
                            sws_next = (a == pcpf_pkg::BACKSLASH);
                        end
                        if (mismatch)
                        begin
                            // Settle the prefix count
                            if (both_end)
                            begin
                                n = pos_e;
                            end
                            else if (sep_end)
                            begin
                                n = (pos_e == 16'd1 && sws_next) ? 16'd0 : pos_e;
                            end
                            else if (sep_next == pcpf_pkg::SEP_NONE)
                            begin
                                n = 16'd0;
                            end
                            else if (sep_next == 16'd1 && sws_next)
                            begin
                                n = 16'd0;
                            end
                            else
                            begin
                                n = sep_next;
                            end
                            if (n == 16'd2)
                            begin
                                n = 16'd3;
                            end
                            stop_next = 1'b1;
                            cnt_next  = n;
                            if (!copy_en_reg)
                            begin
                                len_next = '0;
                                wr_next  = 1'b0;
                            end
                            else
                            begin
                                wr_next = 1'b1;
                                if (n >= 16'(PATH_LIMIT))
                                begin
                                    len_next = '0;
                                end
                                else
                                begin
                                    la_known = (a == 8'd0) ? {1'b0, pos_e}
                                                           : {1'b0, pos_e} + 17'd1;
                                    wn       = ({1'b0, n} < la_known) ? {1'b0, n}
                                                                      : la_known;
                                    len_next = wn[AW-1:0];
                                end
                            end
                        end
                        else
                        begin
                            // Advance along the equal run
                            if (a == pcpf_pkg::BACKSLASH && pos_e != 16'hFFFF)
                            begin
                                sep_next = pos_e;
                            end
                            if (pos_e != 16'hFFFF)
                            begin
                                pos_next = pos_e + 16'd1;
                            end
                            else
                            begin
                                pos_next = pos_e;
                            end
                        end
                    end
                end
                pcpf_pkg::CMD_MISSING:
                begin
                    stop_next = 1'b1;
                    cnt_next  = 16'd0;
                    len_next  = '0;
                    wr_next   = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Decide the read-back for this item against the updated length
    assign len16     = 16'(len_next);
    assign ridx16    = 16'(pair.data.read_index);
    assign rd_ok     = (ridx16 < len16) && (ridx16 < 16'(PATH_LIMIT));
    assign mem_raddr = ridx16[AW-1:0];
    assign fwd       = mem_we && (mem_waddr == mem_raddr);

    // Hold the compare state and the configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 16'd0;
            sep_reg     <= pcpf_pkg::SEP_NONE;
            sws_reg     <= 1'b0;
            stop_reg    <= 1'b0;
            cnt_reg     <= 16'd0;
            len_reg     <= '0;
            wr_reg      <= 1'b0;
            copy_en_reg <= 1'b1;
        end
        else
        begin
            pos_reg  <= pos_next;
            sep_reg  <= sep_next;
            sws_reg  <= sws_next;
            stop_reg <= stop_next;
            cnt_reg  <= cnt_next;
            len_reg  <= len_next;
            wr_reg   <= wr_next;
            if (cfg_we)
            begin
                copy_en_reg <= cfg_wdata;
            end
        end
    end

    // Path A byte store: write at the position, read at the requested index
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= a;
        end
        if (accept && rd_ok)
        begin
            mem_q_reg <= mem[mem_raddr];
        end
    end

    // Stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= accept;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_fin_reg      <= stop_next;
            s1_cnt_reg      <= cnt_next;
            s1_len_reg      <= len16[8:0];
            s1_wr_reg       <= wr_next;
            s1_rd_ok_reg    <= rd_ok;
            s1_fwd_reg      <= fwd;
            s1_fwd_byte_reg <= a;
        end
    end

    // Output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // Output register payload, with the byte read back from the store
    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            out_data_reg.finished       <= s1_fin_reg;
            out_data_reg.prefix_count   <= s1_cnt_reg;
            out_data_reg.copied_length  <= s1_len_reg;
            out_data_reg.buffer_written <= s1_wr_reg;
            if (!s1_rd_ok_reg)
            begin
                out_data_reg.out_byte <= 8'd0;
            end
            else if (s1_fwd_reg)
            begin
                out_data_reg.out_byte <= s1_fwd_byte_reg;
            end
            else
            begin
                out_data_reg.out_byte <= mem_q_reg;
            end
        end
    end

endmodule

// ----- verif/pcpf_prefix_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the folded path common-prefix block: watches both channels
// and the copy_enabled write port, predicts each result and compares it.
// Depends on pcpf_pkg and the channel interfaces in pcpf_if.sv.
module pcpf_prefix_checker #(
    parameter int PATH_LIMIT = 260
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    pcpf_pair_if      pair,
    pcpf_result_if    result,
    output int        errors,
    output int        outstanding
);

    // Predicted block state
    logic        copy_on;
    logic [15:0] run_len;
    logic [15:0] sep_at;
    logic        lead_sep;
    logic        halted;
    logic [7:0]  a_bytes [PATH_LIMIT];
    logic [15:0] held_count;
    logic [8:0]  held_len;
    logic        held_written;

    pcpf_pkg::result_t prefix_reports[$];
    int                mismatch_total;

    // Case-insensitive byte class used for the comparison
    function automatic logic [7:0] casefold(input logic [7:0] c);
        logic [7:0] f;
        begin
            f = c;
            if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'hE0 && c <= 8'hF6) ||
                (c >= 8'hF8 && c <= 8'hFE))
            begin
                f = c - 8'h20;
            end
            else if (c == 8'h9A || c == 8'h9C || c == 8'h9E)
            begin
                f = c - 8'h10;
            end
            else if (c == 8'h88)
            begin
                f = 8'h5E;
            end
            else if (c == 8'hFF)
            begin
                f = 8'h9F;
            end
            return f;
        end
    endfunction

    // Fix the prefix count and copy length at the stop position
    function automatic void settle_prefix(input logic [7:0] a, input logic [7:0] b);
        int k;
        int n;
        int a_len;
        begin
            k = run_len;
            if (a == 8'h00 && b == 8'h00)
            begin
                n = k;
            end
            else if ((a == 8'h00 && b == pcpf_pkg::BACKSLASH) ||
                     (b == 8'h00 && a == pcpf_pkg::BACKSLASH))
            begin
                n = (k == 1 && lead_sep) ? 0 : k;
            end
            else if (sep_at == pcpf_pkg::SEP_NONE || (sep_at == 16'd1 && lead_sep))
            begin
                n = 0;
            end
            else
            begin
                n = sep_at;
            end
            if (n == 2)
                n = 3;

            halted       = 1'b1;
            held_count   = n[15:0];
            held_written = copy_on;
            held_len     = '0;
            if (copy_on && n < PATH_LIMIT)
            begin
                a_len    = (a == 8'h00) ? k : k + 1;
                held_len = (n < a_len) ? n[8:0] : a_len[8:0];
            end
        end
    endfunction

    // Advance the prediction by one item and return the result it reports
    function automatic pcpf_pkg::result_t fold_compare_step(input pcpf_pkg::pair_t p);
        pcpf_pkg::result_t r;
        begin
            if (p.command == pcpf_pkg::CMD_PAIR)
            begin
                if (p.first_pair)
                begin
                    run_len      = '0;
                    sep_at       = pcpf_pkg::SEP_NONE;
                    lead_sep     = 1'b0;
                    halted       = 1'b0;
                    held_count   = '0;
                    held_len     = '0;
                    held_written = 1'b0;
                end
                if (!halted)
                begin
                    if (run_len < PATH_LIMIT)
                        a_bytes[run_len] = p.a_byte;
                    if (run_len == 16'd0)
                        lead_sep = (p.a_byte == pcpf_pkg::BACKSLASH);
                    if (p.a_byte == 8'h00 || p.b_byte == 8'h00 ||
                        casefold(p.a_byte) != casefold(p.b_byte))
                    begin
                        settle_prefix(p.a_byte, p.b_byte);
                    end
                    else
                    begin
                        // hold the position and the separator mark at saturation
                        if (p.a_byte == pcpf_pkg::BACKSLASH && run_len != 16'hFFFF)
                            sep_at = run_len;
                        if (run_len != 16'hFFFF)
                            run_len = run_len + 16'd1;
                    end
                end
            end
            else if (p.command == pcpf_pkg::CMD_MISSING)
            begin
                halted       = 1'b1;
                held_count   = '0;
                held_len     = '0;
                held_written = 1'b0;
            end

            r.finished       = halted;
            r.prefix_count   = held_count;
            r.copied_length  = held_len;
            r.buffer_written = held_written;
            r.out_byte       = 8'h00;
            if (p.read_index < held_len && p.read_index < PATH_LIMIT)
                r.out_byte = a_bytes[p.read_index];
            return r;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pcpf_pkg::result_t want;
        pcpf_pkg::result_t got;
        if (!rst_n)
        begin
            copy_on      = 1'b1;
            run_len      = '0;
            sep_at       = pcpf_pkg::SEP_NONE;
            lead_sep     = 1'b0;
            halted       = 1'b0;
            held_count   = '0;
            held_len     = '0;
            held_written = 1'b0;
            for (int i = 0; i < PATH_LIMIT; i++)
                a_bytes[i] = 8'h00;
            prefix_reports.delete();
            mismatch_total = 0;
            errors      <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                copy_on = cfg_wdata;

            // compare the delivered result against the oldest prediction
            if (result.valid && result.ready)
            begin
                got = result.data;
                if (prefix_reports.size() == 0)
                begin
                    if (mismatch_total < 10)
                        $display("%0t: result with nothing pending:", $realtime,
                                 " fin=%0d cnt=%0d len=%0d wr=%0d byte=%02h",
                                 got.finished, got.prefix_count,
                                 got.copied_length, got.buffer_written, got.out_byte);
                    mismatch_total++;
                end
                else
                begin
                    want = prefix_reports.pop_front();
                    if (got.finished !== want.finished ||
                        got.prefix_count !== want.prefix_count ||
                        got.copied_length !== want.copied_length ||
                        got.buffer_written !== want.buffer_written ||
                        got.out_byte !== want.out_byte)
                    begin
                        if (mismatch_total < 10)
                            $display("%0t: expected", $realtime,
                                     " fin=%0d cnt=%0d len=%0d wr=%0d byte=%02h,",
                                     want.finished, want.prefix_count,
                                     want.copied_length, want.buffer_written,
                                     want.out_byte,
                                     " got fin=%0d cnt=%0d len=%0d wr=%0d byte=%02h",
                                     got.finished, got.prefix_count, got.copied_length,
                                     got.buffer_written, got.out_byte);
                        mismatch_total++;
                    end
                end
            end

            if (pair.valid && pair.ready)
                prefix_reports.push_back(fold_compare_step(pair.data));

            errors      <= mismatch_total;
            outstanding <= prefix_reports.size();
        end
    end

endmodule

// ----- verif/path_common_prefix_folded_test.sv -----
`timescale 1ns / 100ps
// Testbench top for the folded path common-prefix block: drives path pairs,
// reads and missing-path queries, throttles the result side and gives the verdict.
// Depends on pcpf_pkg, pcpf_if.sv, the block and pcpf_prefix_checker.
module path_common_prefix_folded_test;

    localparam int PATH_LIMIT   = 260;
    localparam int PHASE_PAIRS  = 210;
    localparam int HOLD_CYCLES  = 100;
    localparam int STALL_LIMIT  = 1000;
    localparam int SETTLE_WAIT  = 8;
    localparam logic [7:0] FOLD_EDGES [16] = '{
        8'h88, 8'h5E, 8'h9A, 8'h8A, 8'h9C, 8'h8C, 8'h9E, 8'h8E,
        8'hFF, 8'h9F, 8'hE0, 8'hF6, 8'hF7, 8'hF8, 8'hFE, 8'hD7
    };

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cfg_we    = 1'b0;
    logic cfg_wdata = 1'b0;
    int   errors;
    int   outstanding;
    int   quiet;
    int   compared_pairs;
    bit   send_idle = 1'b1;
    logic [7:0] path_a[$];
    logic [7:0] path_b[$];

    pcpf_pair_if   pair_ch();
    pcpf_result_if result_ch();

    path_common_prefix_folded #(
        .PATH_LIMIT (PATH_LIMIT)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pair      (pair_ch),
        .result    (result_ch)
    );

    pcpf_prefix_checker #(
        .PATH_LIMIT (PATH_LIMIT)
    ) prefix_watch (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .pair        (pair_ch),
        .result      (result_ch),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always #2 clk = ~clk;

    // Abort when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (pair_ch.valid && pair_ch.ready) ||
            (result_ch.valid && result_ch.ready))
        begin
            quiet <= 0;
        end
        else if (quiet >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            quiet <= quiet + 1;
        end
    end

    // Result side: random stalls, calm stretches and one long hold-off
    initial
    begin : result_side
        int taken;
        int stall;
        bit calm;
        taken = 0;
        calm  = 1'b0;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        result_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                taken++;
                if (taken % 32 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                if (taken == 150)
                    stall = HOLD_CYCLES;
                else if (calm)
                    stall = 0;
                else
                    stall = $urandom_range(0, 12);
                if (stall > 0)
                begin
                    result_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                    result_ch.ready <= 1'b1;
                end
            end
        end
    end

    // Offer one item, after a random gap when send_idle is set, and wait for it to be taken
    task automatic push_pair(input pcpf_pkg::cmd_t cmd, input logic first,
                             input logic [7:0] a, input logic [7:0] b,
                             input logic [8:0] idx);
        pcpf_pkg::pair_t item;
        int              gap;
        item.command    = cmd;
        item.first_pair = first;
        item.a_byte     = a;
        item.b_byte     = b;
        item.read_index = idx;
        gap = send_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            pair_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pair_ch.valid <= 1'b1;
        pair_ch.data  <= item;
        @(posedge clk);
        while (!pair_ch.ready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every predicted result has been delivered
    task automatic drain();
        pair_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_copy_enable(input logic value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Read index biased toward the short copies most comparisons produce
    function automatic logic [8:0] pick_index();
        logic [8:0] idx;
        if ($urandom_range(0, 2) == 0)
            idx = 9'($urandom_range(0, PATH_LIMIT - 1));
        else
            idx = 9'($urandom_range(0, 12));
        return idx;
    endfunction

    function automatic logic [7:0] path_char();
        int         pick;
        logic [7:0] c;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            c = pcpf_pkg::BACKSLASH;
        else if (pick < 7)
            c = 8'(8'h41 + $urandom_range(0, 25) + ($urandom_range(0, 1) ? 8'h20 : 8'h00));
        else if (pick < 8)
            c = FOLD_EDGES[$urandom_range(0, 15)];
        else
            c = 8'($urandom_range(1, 255));
        return c;
    endfunction

    // Pick a byte of the same fold class, or the byte itself
    function automatic logic [7:0] fold_twin(input logic [7:0] c);
        logic [7:0] alt;
        case ($urandom_range(0, 4))
            0:       alt = c ^ 8'h20;
            1:       alt = c ^ 8'h10;
            2:       alt = c ^ 8'h60;
            3:       alt = c ^ 8'hD6;
            default: alt = c;
        endcase
        return (pcpf_pkg::fold(alt) == pcpf_pkg::fold(c)) ? alt : c;
    endfunction

    // Build path A and a fold-equal path B, then shape how the paths end or diverge
    task automatic build_paths();
        int         len_a;
        int         spot;
        logic [7:0] d;
        path_a.delete();
        path_b.delete();
        len_a = ($urandom_range(0, 39) == 0) ? $urandom_range(255, 300) : $urandom_range(0, 10);
        repeat (len_a) path_a.push_back(path_char());
        foreach (path_a[i])
            path_b.push_back(fold_twin(path_a[i]));
        case ($urandom_range(0, 4))
            1:
            begin
                path_b.push_back(pcpf_pkg::BACKSLASH);
                repeat ($urandom_range(0, 3)) path_b.push_back(path_char());
            end
            2:
            begin
                path_a.push_back(pcpf_pkg::BACKSLASH);
                repeat ($urandom_range(0, 3)) path_a.push_back(path_char());
            end
            3:
            begin
                if (len_a > 0)
                begin
                    spot = $urandom_range(0, len_a - 1);
                    d = 8'($urandom_range(1, 255));
                    while (pcpf_pkg::fold(d) == pcpf_pkg::fold(path_a[spot]))
                        d = 8'($urandom_range(1, 255));
                    path_b[spot] = d;
                end
            end
            4:
            begin
                spot = (len_a > 0) ? $urandom_range(0, len_a - 1) : 0;
                while (path_b.size() > spot)
                    void'(path_b.pop_back());
            end
            default:
            begin
            end
        endcase
    endtask

    // Send pairs from position zero up to and including the stop position
    task automatic stream_paths();
        int         pos;
        bit         done;
        logic [7:0] a;
        logic [7:0] b;
        pos  = 0;
        done = 1'b0;
        while (!done)
        begin
            a = (pos < path_a.size()) ? path_a[pos] : 8'h00;
            b = (pos < path_b.size()) ? path_b[pos] : 8'h00;
            done = (a == 8'h00 || b == 8'h00 || pcpf_pkg::fold(a) != pcpf_pkg::fold(b));
            push_pair(pcpf_pkg::CMD_PAIR, pos == 0, a, b, pick_index());
            compared_pairs++;
            pos++;
        end
    endtask

    // Mostly whole comparisons with readback, some raw noise items
    task automatic random_phase(input int quota);
        int stop_at;
        stop_at = compared_pairs + quota;
        while (compared_pairs < stop_at)
        begin
            send_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 8)
            begin
                build_paths();
                stream_paths();
                repeat ($urandom_range(0, 3))
                    push_pair(pcpf_pkg::CMD_READ, 1'($urandom_range(0, 1)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              pick_index());
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    push_pair(pcpf_pkg::cmd_t'($urandom_range(0, 3)),
                              1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), pick_index());
            end
        end
    endtask

    initial
    begin
        pair_ch.valid <= 1'b0;
        pair_ch.data  <= '0;
        compared_pairs = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_copy_enable(1'b1);

        // continue at position zero without a start mark: "\a\b" against "\A\c"
        push_pair(pcpf_pkg::CMD_PAIR, 1'b0, pcpf_pkg::BACKSLASH, pcpf_pkg::BACKSLASH, 9'd0);
        push_pair(pcpf_pkg::CMD_PAIR, 1'b0, 8'h61, 8'h41, 9'd0);
        push_pair(pcpf_pkg::CMD_PAIR, 1'b0, pcpf_pkg::BACKSLASH, pcpf_pkg::BACKSLASH, 9'd1);
        push_pair(pcpf_pkg::CMD_PAIR, 1'b0, 8'h62, 8'h63, 9'd2);
        // pairs after the stop are ignored; read inside and past the copy
        push_pair(pcpf_pkg::CMD_PAIR, 1'b0, 8'h78, 8'h78, 9'd3);
        push_pair(pcpf_pkg::CMD_READ, 1'b0, 8'h00, 8'h00, 9'd2);
        push_pair(pcpf_pkg::CMD_READ, 1'b1, 8'hFF, 8'hFF, 9'd259);
        // same path with the odd fold pairs; count of two reported as three
        push_pair(pcpf_pkg::CMD_PAIR, 1'b1, 8'hFF, 8'h9F, 9'd0);
        push_pair(pcpf_pkg::CMD_PAIR, 1'b0, 8'h88, 8'h5E, 9'd1);
        push_pair(pcpf_pkg::CMD_PAIR, 1'b0, 8'h00, 8'h00, 9'd1);
        // lone leading separator against a separator
        push_pair(pcpf_pkg::CMD_PAIR, 1'b1, pcpf_pkg::BACKSLASH, pcpf_pkg::BACKSLASH, 9'd0);
        push_pair(pcpf_pkg::CMD_PAIR, 1'b0, 8'h00, pcpf_pkg::BACKSLASH, 9'd0);
        // UNC root only in common
        push_pair(pcpf_pkg::CMD_PAIR, 1'b1, pcpf_pkg::BACKSLASH, pcpf_pkg::BACKSLASH, 9'd0);
        push_pair(pcpf_pkg::CMD_PAIR, 1'b0, pcpf_pkg::BACKSLASH, pcpf_pkg::BACKSLASH, 9'd1);
        push_pair(pcpf_pkg::CMD_PAIR, 1'b0, 8'h61, 8'h62, 9'd0);
        // empty paths, terminator against the top byte, missing path, unused code
        push_pair(pcpf_pkg::CMD_PAIR, 1'b1, 8'h00, 8'h00, 9'd0);
        push_pair(pcpf_pkg::CMD_PAIR, 1'b1, 8'h00, 8'hFF, 9'd256);
        push_pair(pcpf_pkg::CMD_PAIR, 1'b1, 8'hFE, 8'hDE, 9'd0);
        push_pair(pcpf_pkg::CMD_MISSING, 1'b0, 8'h41, 8'h41, 9'd0);
        push_pair(pcpf_pkg::CMD_UNUSED, 1'b1, 8'h5C, 8'h00, 9'd0);

        random_phase(PHASE_PAIRS);
        write_copy_enable(1'b0);
        random_phase(PHASE_PAIRS);
        write_copy_enable(1'b1);
        random_phase(PHASE_PAIRS);

        drain();
        repeat (SETTLE_WAIT) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
sv/pcpf_pkg.sv
sv/pcpf_if.sv
sv/path_common_prefix_folded.sv
verif/pcpf_prefix_checker.sv
verif/path_common_prefix_folded_test.sv
